/* rtl/core/olte_pkg.sv */
// ----------------------------------------------------------------------------
// olte_pkg
// Shared types and constants of the ordered list table engine.
// ----------------------------------------------------------------------------
package olte_pkg;

  localparam int DATA_W           = 32;
  localparam int MODE_W           = 2;
  localparam int POS_W            = 7;
  localparam int COUNT_OUT_W      = 7;
  localparam int STATUS_W         = 2;
  localparam int DEFAULT_CAPACITY = 64;

  typedef enum logic [MODE_W-1:0] {
    OP_ORDERED   = 2'd0,
    OP_INSERT_AT = 2'd1,
    OP_READ      = 2'd2,
    OP_REMOVE    = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_RANGE     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

endpackage

/* rtl/core/olte_ram.sv */
// ----------------------------------------------------------------------------
// olte_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module olte_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/ordered_list_table_engine_top.sv */
// ----------------------------------------------------------------------------
// ordered_list_table_engine_top
// Ordered list of signed values held in a RAM, with ordered insert,
// positional insert, read and remove.
//
//   Channel  | Handshake           | Payload
//   ---------+---------------------+--------------------------------------------
//   command  | start, busy         | in_mode, in_value, in_position
//   result   | out_valid (strobe)  | out_read_value, out_status,
//            |                     | out_entry_count, out_is_empty
//
// A transfer is taken when start is high and busy is low; its result shows on the
// strobe in the cycle after the operation's last cycle, when busy is low again.
// Refused positional inserts, reads and removes, positional appends and removes
// of the last entry finish when taken; other reads pass S_READ, removes S_SHD,
// inserts S_SHU and S_WRV. An ordered insert scans one entry a cycle and reports
// a duplicate or full list or inserts before the first larger entry or at the
// end. Only state, count and strobe are reset. The receiver cannot stall.
// ----------------------------------------------------------------------------
module ordered_list_table_engine_top
  import olte_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [MODE_W-1:0]          in_mode,
  input  logic signed [DATA_W-1:0]   in_value,
  input  logic [POS_W-1:0]           in_position,
  output logic                       out_valid,
  output logic signed [DATA_W-1:0]   out_read_value,
  output logic [STATUS_W-1:0]        out_status,
  output logic [COUNT_OUT_W-1:0]     out_entry_count,
  output logic                       out_is_empty
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_SCAN, S_SHU, S_WRV, S_SHD
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic [AW-1:0]            idx_r, idx_nxt;
  logic [AW-1:0]            k_r, k_nxt;
  logic signed [DATA_W-1:0] value_r, value_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_read_value_r, out_read_value_nxt;
  status_t                  out_status_r, out_status_nxt;
  logic [COUNT_OUT_W-1:0]   out_entry_count_r, out_entry_count_nxt;
  logic                     out_is_empty_r, out_is_empty_nxt;

  logic                     ram_we, ram_re;
  logic [AW-1:0]            ram_waddr, ram_raddr;
  logic [DATA_W-1:0]        ram_wdata, ram_rdata;
  logic signed [DATA_W-1:0] rd_s;

  logic                     fin;
  status_t                  fin_status;
  logic                     do_ins;
  logic [AW-1:0]            ins_k;
  logic                     full;
  logic [CMPW-1:0]          pos_in, count_ext, fin_cnt_ext;
  logic [CW-1:0]            cm1, idxp1;

  olte_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_s      = $signed(ram_rdata);
  assign full      = (count_r == CW'(CAPACITY));
  assign pos_in    = CMPW'(in_position);
  assign count_ext = CMPW'(count_r);
  assign cm1       = count_r - CW'(1);
  assign idxp1     = CW'(idx_r) + CW'(1);

  always_comb begin
    state_nxt          = state_r;
    count_nxt          = count_r;
    idx_nxt            = idx_r;
    k_nxt              = k_r;
    value_nxt          = value_r;
    out_valid_nxt      = 1'b0;
    out_read_value_nxt = out_read_value_r;
    fin                = 1'b0;
    fin_status         = ST_DONE;
    do_ins             = 1'b0;
    ins_k              = '0;
    ram_we             = 1'b0;
    ram_re             = 1'b0;
    ram_waddr          = '0;
    ram_raddr          = '0;
    ram_wdata          = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          value_nxt = in_value;
          unique case (op_t'(in_mode))
            OP_ORDERED: begin
              if (count_r == '0) begin
                do_ins = 1'b1;
                ins_k  = '0;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                idx_nxt   = '0;
                state_nxt = S_SCAN;
              end
            end
            OP_INSERT_AT: begin
              if (full) begin
                fin        = 1'b1;
                fin_status = ST_FULL;
              end else begin
                do_ins = 1'b1;
                ins_k  = (pos_in < count_ext) ? pos_in[AW-1:0] : count_ext[AW-1:0];
              end
            end
            OP_READ: begin
              if (pos_in >= count_ext) begin
                fin        = 1'b1;
                fin_status = ST_RANGE;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = pos_in[AW-1:0];
                state_nxt = S_READ;
              end
            end
            OP_REMOVE: begin
              if (pos_in >= count_ext) begin
                fin        = 1'b1;
                fin_status = ST_RANGE;
              end else if ((pos_in + CMPW'(1)) < count_ext) begin
                ram_re    = 1'b1;
                ram_raddr = pos_in[AW-1:0] + AW'(1);
                idx_nxt   = pos_in[AW-1:0] + AW'(1);
                state_nxt = S_SHD;
              end else begin
                count_nxt = cm1;
                fin       = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        fin                = 1'b1;
        out_read_value_nxt = rd_s;
        state_nxt          = S_IDLE;
      end
      S_SCAN: begin
        if (value_r > rd_s) begin
          if (idxp1 < count_r) begin
            ram_re    = 1'b1;
            ram_raddr = idxp1[AW-1:0];
            idx_nxt   = idxp1[AW-1:0];
          end else if (full) begin
            fin        = 1'b1;
            fin_status = ST_FULL;
            state_nxt  = S_IDLE;
          end else begin
            do_ins = 1'b1;
            ins_k  = count_r[AW-1:0];
          end
        end else if (value_r == rd_s) begin
          fin        = 1'b1;
          fin_status = ST_DUPLICATE;
          state_nxt  = S_IDLE;
        end else if (full) begin
          fin        = 1'b1;
          fin_status = ST_FULL;
          state_nxt  = S_IDLE;
        end else begin
          do_ins = 1'b1;
          ins_k  = idx_r;
        end
      end
      S_SHU: begin
        ram_we    = 1'b1;
        ram_waddr = idxp1[AW-1:0];
        ram_wdata = ram_rdata;
        if (idx_r > k_r) begin
          ram_re    = 1'b1;
          ram_raddr = idx_r - AW'(1);
          idx_nxt   = idx_r - AW'(1);
        end else begin
          state_nxt = S_WRV;
        end
      end
      S_WRV: begin
        ram_we    = 1'b1;
        ram_waddr = k_r;
        ram_wdata = value_r;
        count_nxt = count_r + CW'(1);
        fin       = 1'b1;
        state_nxt = S_IDLE;
      end
      S_SHD: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r - AW'(1);
        ram_wdata = ram_rdata;
        if (idxp1 < count_r) begin
          ram_re    = 1'b1;
          ram_raddr = idxp1[AW-1:0];
          idx_nxt   = idxp1[AW-1:0];
        end else begin
          count_nxt = cm1;
          fin       = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (do_ins) begin
      k_nxt = ins_k;
      if (CW'(ins_k) < count_r) begin
        ram_re    = 1'b1;
        ram_raddr = cm1[AW-1:0];
        idx_nxt   = cm1[AW-1:0];
        state_nxt = S_SHU;
      end else begin
        ram_we    = 1'b1;
        ram_waddr = ins_k;
        ram_wdata = (state_r == S_IDLE) ? in_value : value_r;
        count_nxt = count_r + CW'(1);
        fin       = 1'b1;
        state_nxt = S_IDLE;
      end
    end

    fin_cnt_ext = CMPW'(count_nxt);
    if (fin) begin
      out_valid_nxt       = 1'b1;
      out_status_nxt      = fin_status;
      out_entry_count_nxt = fin_cnt_ext[COUNT_OUT_W-1:0];
      out_is_empty_nxt    = (count_nxt == '0);
      if (state_r != S_READ) begin
        out_read_value_nxt = '0;
      end
    end else begin
      out_status_nxt      = out_status_r;
      out_entry_count_nxt = out_entry_count_r;
      out_is_empty_nxt    = out_is_empty_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r             <= idx_nxt;
    k_r               <= k_nxt;
    value_r           <= value_nxt;
    out_read_value_r  <= out_read_value_nxt;
    out_status_r      <= out_status_nxt;
    out_entry_count_r <= out_entry_count_nxt;
    out_is_empty_r    <= out_is_empty_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_read_value  = out_read_value_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_entry_count_r;
  assign out_is_empty    = out_is_empty_r;

endmodule

/* rtl/core/olte_checker.sv */
// ----------------------------------------------------------------------------
// olte_checker
// Port-level checks of the ordered list table engine, bound to the top level.
// ----------------------------------------------------------------------------
module olte_checker
  import olte_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     start,
  input logic                     busy,
  input logic                     out_valid,
  input logic signed [DATA_W-1:0] out_read_value,
  input logic [STATUS_W-1:0]      out_status,
  input logic [COUNT_OUT_W-1:0]   out_entry_count,
  input logic                     out_is_empty
);

  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("Result shown while the engine is busy.");

  a_transfer_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid || busy))
    else $error("Accepted transfer neither finished nor kept the engine busy.");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_empty) |-> (out_entry_count == '0))
    else $error("Empty flag set with a non-zero count.");

  a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_DONE)) |-> (out_read_value == '0))
    else $error("Non-zero read value on a failed operation.");

endmodule

bind ordered_list_table_engine_top olte_checker u_olte_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_read_value (out_read_value),
  .out_status     (out_status),
  .out_entry_count(out_entry_count),
  .out_is_empty   (out_is_empty)
);
